// File: hw/rtl/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// No dependencies; imported by every module of the block except the RAM.
package ffpa_pkg;

   localparam int POOL_UNITS  = 128;
   localparam int IDX_W       = $clog2(POOL_UNITS);
   localparam int CNT_W       = $clog2(POOL_UNITS + 1);
   localparam int VALUE_W     = 8;
   localparam int ADDR_W      = 7;
   localparam int DATA_W      = 8;
   localparam int ENTRY_W     = 2;
   localparam int ENT_ALLOC   = 0;
   localparam int ENT_START   = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   // arg: size for an alloc, start address for a free
   typedef struct packed {
      kind_type           kind;
      logic [CNT_W-1:0]   arg;
   } cmd_type;

endpackage

// File: hw/rtl/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffpa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ffpa_front.sv
// Front end: takes request items, classifies them and queues commands.
// Depends on ffpa_pkg.
module ffpa_front import ffpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_op,
   input  logic [VALUE_W-1:0] req_value,
   output logic               q_valid,
   output cmd_type            q_cmd,
   input  logic               q_pop
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_c;
   logic                push;
   logic                pop;

   // Range checks happen here; the back end gets out-of-range items only as rejects.
   always_comb begin
      cmd_c.arg = CNT_W'(req_value);
      if (!req_op) begin
         if ((req_value != '0) && (32'(req_value) <= 32'(POOL_UNITS))) begin
            cmd_c.kind = KIND_ALLOC;
         end else begin
            cmd_c.kind = KIND_REJECT;
         end
      end else begin
         if (32'(req_value) < 32'(POOL_UNITS)) begin
            cmd_c.kind = KIND_FREE;
         end else begin
            cmd_c.kind = KIND_REJECT;
         end
      end
   end

   assign req_tready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_c;
      end
   end

endmodule

// File: hw/rtl/ffpa_back.sv
// Back end: sequencer that scans, fills and frees the unit map in RAM.
// Depends on ffpa_pkg and ffpa_ram.
module ffpa_back import ffpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_ok,
   output logic [ADDR_W-1:0] rsp_addr
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SCAN     = 5'b00010,
      ST_FILL     = 5'b00100,
      ST_FREE_CHK = 5'b01000,
      ST_RESULT   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]     run_begin_ff, run_begin_in;
   logic [CNT_W-1:0]     run_len_ff, run_len_in;
   logic [IDX_W-1:0]     start_ff, start_in;
   logic [IDX_W-1:0]     fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0]     fill_left_ff, fill_left_in;
   logic                 first_ff, first_in;
   logic                 res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [POOL_UNITS-1:0] valid_ff, valid_in;

   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 unit_alloc;
   logic                 unit_start;
   logic [CNT_W-1:0]     len_next;
   logic [IDX_W-1:0]     begin_next;

   ffpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POOL_UNITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A unit never written since reset reads as free, no block start.
   assign unit_alloc = valid_ff[rd_addr_ff] & ram_rd_data[ENT_ALLOC];
   assign unit_start = valid_ff[rd_addr_ff] & ram_rd_data[ENT_START];
   assign len_next   = CNT_W'(run_len_ff + 1'b1);
   assign begin_next = (run_len_ff == '0) ? rd_addr_ff : run_begin_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      rd_addr_in   = rd_addr_ff;
      run_begin_in = run_begin_ff;
      run_len_in   = run_len_ff;
      start_in     = start_ff;
      fill_addr_in = fill_addr_ff;
      fill_left_in = fill_left_ff;
      first_in     = first_ff;
      res_ok_in    = res_ok_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      q_pop        = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.kind)
                  KIND_ALLOC: begin
                     idx_in     = '0;
                     run_len_in = '0;
                     state_in   = ST_SCAN;
                  end
                  KIND_FREE: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = q_cmd.arg[IDX_W-1:0];
                     rd_addr_in  = q_cmd.arg[IDX_W-1:0];
                     first_in    = 1'b1;
                     state_in    = ST_FREE_CHK;
                  end
                  default: begin
                     res_ok_in   = 1'b0;
                     res_addr_in = '0;
                     state_in    = ST_RESULT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one read in flight; pend_ff marks data for rd_addr_ff
            if (pend_ff && !unit_alloc && (len_next >= cmd_ff.arg)) begin
               start_in     = begin_next;
               fill_addr_in = begin_next;
               fill_left_in = cmd_ff.arg;
               state_in     = ST_FILL;
            end else begin
               if (pend_ff) begin
                  if (unit_alloc) begin
                     run_len_in = '0;
                  end else begin
                     run_begin_in = begin_next;
                     run_len_in   = len_next;
                  end
               end
               if (idx_ff < CNT_W'(POOL_UNITS)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff[IDX_W-1:0];
                  rd_addr_in  = idx_ff[IDX_W-1:0];
                  pend_in     = 1'b1;
                  idx_in      = CNT_W'(idx_ff + 1'b1);
               end else if (!pend_ff) begin
                  res_ok_in   = 1'b0;
                  res_addr_in = '0;
                  state_in    = ST_RESULT;
               end
            end
         end
         ST_FILL: begin
            ram_wr_en              = 1'b1;
            ram_wr_addr            = fill_addr_ff;
            ram_wr_data[ENT_ALLOC] = 1'b1;
            ram_wr_data[ENT_START] = (fill_addr_ff == start_ff);
            fill_addr_in           = IDX_W'(fill_addr_ff + 1'b1);
            fill_left_in           = CNT_W'(fill_left_ff - 1'b1);
            if (fill_left_ff == CNT_W'(1)) begin
               res_ok_in   = 1'b1;
               res_addr_in = ADDR_W'(start_ff);
               state_in    = ST_RESULT;
            end
         end
         ST_FREE_CHK: begin
            first_in    = 1'b0;
            res_addr_in = '0;
            if (first_ff ? !(unit_alloc && unit_start) : (!unit_alloc || unit_start)) begin
               // first unit not a live block start: fail; later: block ended
               res_ok_in = !first_ff;
               state_in  = ST_RESULT;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_addr_ff;
               ram_wr_data = '0;
               if (rd_addr_ff == IDX_W'(POOL_UNITS - 1)) begin
                  res_ok_in = 1'b1;
                  state_in  = ST_RESULT;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(rd_addr_ff + 1'b1);
                  rd_addr_in  = IDX_W'(rd_addr_ff + 1'b1);
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_addr_in  = res_addr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      rd_addr_ff   <= rd_addr_in;
      run_begin_ff <= run_begin_in;
      run_len_ff   <= run_len_in;
      start_ff     <= start_in;
      fill_addr_ff <= fill_addr_in;
      fill_left_ff <= fill_left_in;
      first_ff     <= first_in;
      res_ok_ff    <= res_ok_in;
      res_addr_ff  <= res_addr_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_addr   = rsp_addr_ff;

endmodule

// File: hw/rtl/first_fit_pool_allocator.sv
// First-fit pool allocator, top level. One result item per request item, in order.
// Request: scan (one unit map read per cycle), then fill of size units, then result;
// release: check of the start unit, then clearing of the freed block, then result.
// The back end sequencer handles one item at a time; a two-entry queue lets the
// front take items meanwhile. Synchronous reset clears the queue, the sequencer
// and the per-unit valid bits: the whole pool reads free, no sweep.
module first_fit_pool_allocator import ffpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [7:0] value
   input  logic              req_tuser,   // [0] op
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [6:0] addr, [7] zero
   output logic              rsp_tuser    // [0] ok
);

   logic              q_valid;
   cmd_type           q_cmd;
   logic              q_pop;
   logic [ADDR_W-1:0] rsp_addr;

   ffpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   ffpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_ok     (rsp_tuser),
      .rsp_addr   (rsp_addr)
   );

   assign rsp_tdata = DATA_W'(rsp_addr);

endmodule

// File: bench/testbench.sv
// Self-checking bench for first_fit_pool_allocator: table-driven directed items,
// then random request/release traffic checked against an in-bench pool predictor.
// Depends on ffpa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module testbench;
   import ffpa_pkg::*;

   localparam logic OP_REQUEST  = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;
   localparam logic ST_FAIL     = 1'b0;
   localparam logic ST_OK       = 1'b1;
   localparam int DIR_ROWS        = 25;
   localparam int RAND_ITEMS      = 1725;
   localparam int IDLE_PCT        = 11;
   localparam int RSP_HOLD_CYCLES = 1000;
   localparam int DRAIN_CYCLES    = 400;
   localparam int CYCLE_LIMIT     = 2_000_000;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
   } grant_type;

   typedef struct packed {
      logic               op;
      logic [VALUE_W-1:0] value;
      logic               typed;   // want holds a hand-written expectation
      grant_type          want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // [7:0] value
   logic              req_tuser = 1'b0; // [0] op
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // [6:0] addr, [7] zero
   logic              rsp_tuser;        // [0] ok

   // predictor copy of the pool
   logic [POOL_UNITS-1:0] pool_used = '0;
   logic [POOL_UNITS-1:0] pool_head = '0;
   grant_type             grants_due [$];

   int  mismatches    = 0;
   int  cycle_count   = 0;
   int  hold_requests = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   bit  quiet         = 1'b0;
   grant_type seen_want;

   // Hole-finding rows fall back on the predictor; the rest are read off by hand.
   dir_row_type dir_table [DIR_ROWS] = '{
      '{OP_REQUEST, 8'd0,   1'b1, '{ST_FAIL, 7'd0}},  // zero size
      '{OP_REQUEST, 8'd129, 1'b1, '{ST_FAIL, 7'd0}},  // oversize
      '{OP_REQUEST, 8'd255, 1'b1, '{ST_FAIL, 7'd0}},
      '{OP_RELEASE, 8'd0,   1'b1, '{ST_FAIL, 7'd0}},  // nothing allocated
      '{OP_RELEASE, 8'd128, 1'b1, '{ST_FAIL, 7'd0}},  // out of range
      '{OP_RELEASE, 8'd255, 1'b1, '{ST_FAIL, 7'd0}},
      '{OP_REQUEST, 8'd128, 1'b1, '{ST_OK,   7'd0}},  // whole pool
      '{OP_REQUEST, 8'd1,   1'b1, '{ST_FAIL, 7'd0}},  // pool full
      '{OP_RELEASE, 8'd0,   1'b1, '{ST_OK,   7'd0}},
      '{OP_REQUEST, 8'd1,   1'b1, '{ST_OK,   7'd0}},
      '{OP_REQUEST, 8'd3,   1'b0, '0},
      '{OP_REQUEST, 8'd124, 1'b0, '0},
      '{OP_RELEASE, 8'd1,   1'b0, '0},
      '{OP_RELEASE, 8'd2,   1'b1, '{ST_FAIL, 7'd0}},  // not a block start
      '{OP_REQUEST, 8'd2,   1'b0, '0},
      '{OP_REQUEST, 8'd2,   1'b0, '0},                // hole too short
      '{OP_REQUEST, 8'd1,   1'b0, '0},
      '{OP_RELEASE, 8'd4,   1'b0, '0},
      '{OP_RELEASE, 8'd1,   1'b0, '0},                // stops at next block start
      '{OP_RELEASE, 8'd0,   1'b0, '0},
      '{OP_RELEASE, 8'd3,   1'b0, '0},
      '{OP_REQUEST, 8'd128, 1'b1, '{ST_OK,   7'd0}},  // free space merged again
      '{OP_RELEASE, 8'd127, 1'b1, '{ST_FAIL, 7'd0}},
      '{OP_RELEASE, 8'd0,   1'b1, '{ST_OK,   7'd0}},
      '{OP_REQUEST, 8'd127, 1'b0, '0}
   };

   first_fit_pool_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // First fit over the unit map; a release frees up to the next block start.
   task automatic pool_apply(input logic op, input logic [VALUE_W-1:0] value,
                             output grant_type g);
      int run_begin;
      int run_len;
      int fit;
      int u;
      g = '{ok: ST_FAIL, addr: '0};
      if (op == OP_REQUEST) begin
         if (value != 0 && value <= POOL_UNITS) begin
            fit = -1;
            run_len = 0;
            run_begin = 0;
            for (u = 0; u < POOL_UNITS && fit < 0; u++) begin
               if (pool_used[u]) begin
                  run_len = 0;
               end else begin
                  if (run_len == 0) run_begin = u;
                  run_len++;
                  if (run_len >= value) fit = run_begin;
               end
            end
            if (fit >= 0) begin
               for (u = fit; u < fit + value && u < POOL_UNITS; u++) pool_used[u] = 1'b1;
               pool_head[fit] = 1'b1;
               g.ok = ST_OK;
               g.addr = fit[ADDR_W-1:0];
            end
         end
      end else if (value < POOL_UNITS && pool_used[value] && pool_head[value]) begin
         pool_head[value] = 1'b0;
         pool_used[value] = 1'b0;
         for (u = value + 1; u < POOL_UNITS && pool_used[u] && !pool_head[u]; u++)
            pool_used[u] = 1'b0;
         g.ok = ST_OK;
      end
   endtask

   task automatic offer(input logic op, input logic [VALUE_W-1:0] value,
                        input logic typed, input grant_type want);
      grant_type g;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pool_apply(op, value, g);
      grants_due.push_back(typed ? want : g);
   endtask

   initial begin
      int n;
      int r;
      int u;
      int heads;
      int pick;
      logic op;
      logic [VALUE_W-1:0] value;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIR_ROWS; n++)
         offer(dir_table[n].op, dir_table[n].value, dir_table[n].typed, dir_table[n].want);

      for (n = 0; n < RAND_ITEMS; n++) begin
         quiet = (n >= 900 && n < 1150);
         if (n % 350 == 0) begin
            // sender waits for the block to drain completely
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (grants_due.size() != 0) @(posedge clock);
         end
         if (n == 400) hold_requests++;

         heads = 0;
         for (u = 0; u < POOL_UNITS; u++) if (pool_head[u]) heads++;
         r = $urandom_range(99);
         op = OP_REQUEST;
         if (r < 85 && r >= 45 && heads > 0) begin
            pick = $urandom_range(heads - 1);
            op = OP_RELEASE;
            for (u = 0; u < POOL_UNITS; u++) begin
               if (pool_head[u]) begin
                  if (pick == 0) value = u[VALUE_W-1:0];
                  pick--;
               end
            end
         end else if (r < 85) begin
            value = VALUE_W'(($urandom_range(9) == 0) ? $urandom_range(9, POOL_UNITS)
                                                      : $urandom_range(1, 8));
         end else begin
            op = 1'($urandom_range(1));
            value = VALUE_W'($urandom_range(255));
         end
         offer(op, value, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (grants_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, none while quiet.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = RSP_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grants_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: ok %0d tdata 0x%02h", rsp_tuser, rsp_tdata);
         end else begin
            seen_want = grants_due.pop_front();
            if (rsp_tuser !== seen_want.ok || rsp_tdata !== {1'b0, seen_want.addr}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected ok %0d addr %0d, got ok %0d tdata 0x%02h",
                           seen_want.ok, seen_want.addr, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
